### hw/rtl/crsg_pkg.sv
// Shared types and constants for the LTE cell-specific reference signal generator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package crsg_pkg;

    localparam int MAX_RB         = 110;
    localparam int RES_PER_RESULT = 8;
    localparam int GOLD_SKIP      = 1600;
    localparam int LOC_STEP       = 6 * RES_PER_RESULT;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int CELL_W  = 9;
    localparam int RB_W    = 7;
    localparam int SPS_W   = 3;
    localparam int SLOT_W  = 5;
    localparam int SYM_W   = 3;
    localparam int PORT_W  = 2;
    localparam int LOC_W   = 11;
    localparam int BITS_W  = 8;
    localparam int CNT_W   = 4;
    localparam int SEED_W  = 31;
    localparam int SHIFT_W = 3;
    localparam int SKIP_W  = 11;
    localparam int ELEM_W  = 8;
    localparam int K_W     = 3;

    localparam logic [1:0] REG_CELL_ID   = 2'd0;
    localparam logic [1:0] REG_NUM_RB    = 2'd1;
    localparam logic [1:0] REG_SYM_SLOT  = 2'd2;
    localparam logic [1:0] REG_NORMAL_CP = 2'd3;

    localparam logic [PORT_W-1:0] PORT_0 = 2'd0;
    localparam logic [PORT_W-1:0] PORT_1 = 2'd1;
    localparam logic [PORT_W-1:0] PORT_2 = 2'd2;
    localparam logic [PORT_W-1:0] PORT_3 = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SEED = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_SKIP = 5'b01000,
        ST_GEN  = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } gold_ctrl_t;

endpackage

### hw/rtl/lte_cell_reference_signal_gen_unit.sv
// A symbol without reference signals is accepted and gives no output. Otherwise groups of up
// to eight elements follow, paced by the bit-serial Gold sequence, which advances one step per
// cycle while it skips or fills a group and holds while a full group waits on out_ready.
// Input is not taken while a symbol runs. Reset clears the configuration registers to their
// defaults and the sequencer.
// Depends on crsg_pkg, crsg_seed and crsg_gold.
module lte_cell_reference_signal_gen_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crsg_pkg::ADDR_W-1:0]       paddr,
    input  logic [crsg_pkg::DATA_W-1:0]       pwdata,
    output logic [crsg_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [crsg_pkg::SLOT_W-1:0]       slot,
    input  logic [crsg_pkg::SYM_W-1:0]        symbol,
    input  logic [crsg_pkg::PORT_W-1:0]       antenna_port,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [crsg_pkg::LOC_W-1:0]        first_location,
    output logic [crsg_pkg::BITS_W-1:0]       real_bits,
    output logic [crsg_pkg::BITS_W-1:0]       imag_bits,
    output logic [crsg_pkg::CNT_W-1:0]        valid_count,
    output logic                              last_group
);

    logic [crsg_pkg::CELL_W-1:0]  cell_id_reg;
    logic [crsg_pkg::RB_W-1:0]    num_rb_reg;
    logic [crsg_pkg::SPS_W-1:0]   sym_slot_reg;
    logic                         normal_cp_reg;

    crsg_pkg::state_t             state_reg;
    crsg_pkg::state_t             state_next;
    logic [crsg_pkg::SLOT_W-1:0]  slot_reg;
    logic [crsg_pkg::SLOT_W-1:0]  slot_next;
    logic [crsg_pkg::SYM_W-1:0]   symbol_reg;
    logic [crsg_pkg::SYM_W-1:0]   symbol_next;
    logic [crsg_pkg::SHIFT_W-1:0] v_reg;
    logic [crsg_pkg::SHIFT_W-1:0] v_next;
    logic [crsg_pkg::SKIP_W-1:0]  skip_reg;
    logic [crsg_pkg::SKIP_W-1:0]  skip_next;
    logic [crsg_pkg::ELEM_W-1:0]  left_reg;
    logic [crsg_pkg::ELEM_W-1:0]  left_next;
    logic [crsg_pkg::CNT_W-1:0]   n_reg;
    logic [crsg_pkg::CNT_W-1:0]   n_next;
    logic [crsg_pkg::K_W-1:0]     k_reg;
    logic [crsg_pkg::K_W-1:0]     k_next;
    logic                         phase_reg;
    logic                         phase_next;
    logic                         full_reg;
    logic                         full_next;
    logic [crsg_pkg::BITS_W-1:0]  re_reg;
    logic [crsg_pkg::BITS_W-1:0]  re_next;
    logic [crsg_pkg::BITS_W-1:0]  im_reg;
    logic [crsg_pkg::BITS_W-1:0]  im_next;
    logic [crsg_pkg::LOC_W-1:0]   loc_reg;
    logic [crsg_pkg::LOC_W-1:0]   loc_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [crsg_pkg::LOC_W-1:0]   out_loc_reg;
    logic [crsg_pkg::BITS_W-1:0]  out_re_reg;
    logic [crsg_pkg::BITS_W-1:0]  out_im_reg;
    logic [crsg_pkg::CNT_W-1:0]   out_cnt_reg;
    logic                         out_last_reg;

    logic                         cfg_write;
    logic                         in_accept;
    logic                         has_rs;
    logic [crsg_pkg::SHIFT_W-1:0] v_sel;
    logic [crsg_pkg::RB_W-1:0]    rb;
    logic [crsg_pkg::SKIP_W-1:0]  skip_len;
    logic [crsg_pkg::ELEM_W-1:0]  total;
    logic [crsg_pkg::ELEM_W-1:0]  left_after;
    logic                         is_last;
    logic                         emit;
    logic                         seed_start;
    logic [crsg_pkg::SEED_W-1:0]  seed;
    logic [crsg_pkg::SHIFT_W-1:0] freq_shift;
    crsg_pkg::gold_ctrl_t         gold_ctrl;
    logic                         gold_bit;

    function automatic logic [crsg_pkg::CNT_W-1:0] group_size(
        input logic [crsg_pkg::ELEM_W-1:0] left);
        logic [crsg_pkg::CNT_W-1:0] n;
        begin
            if (left > crsg_pkg::ELEM_W'(crsg_pkg::RES_PER_RESULT))
            begin
                n = crsg_pkg::CNT_W'(crsg_pkg::RES_PER_RESULT);
            end
            else
            begin
                n = left[crsg_pkg::CNT_W-1:0];
            end
            return n;
        end
    endfunction

    crsg_seed u_seed (
        .clk        (clk),
        .start      (seed_start),
        .slot       (slot_reg),
        .symbol     (symbol_reg),
        .cell_id    (cell_id_reg),
        .normal_cp  (normal_cp_reg),
        .v          (v_reg),
        .seed       (seed),
        .freq_shift (freq_shift)
    );

    crsg_gold u_gold (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (gold_ctrl),
        .seed    (seed),
        .bit_out (gold_bit)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            crsg_pkg::REG_CELL_ID:   prdata = {23'd0, cell_id_reg};
            crsg_pkg::REG_NUM_RB:    prdata = {25'd0, num_rb_reg};
            crsg_pkg::REG_SYM_SLOT:  prdata = {29'd0, sym_slot_reg};
            crsg_pkg::REG_NORMAL_CP: prdata = {31'd0, normal_cp_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_id_reg   <= '0;
            num_rb_reg    <= crsg_pkg::RB_W'(crsg_pkg::MAX_RB);
            sym_slot_reg  <= 3'd7;
            normal_cp_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                crsg_pkg::REG_CELL_ID:   cell_id_reg   <= pwdata[crsg_pkg::CELL_W-1:0];
                crsg_pkg::REG_NUM_RB:    num_rb_reg    <= pwdata[crsg_pkg::RB_W-1:0];
                crsg_pkg::REG_SYM_SLOT:  sym_slot_reg  <= pwdata[crsg_pkg::SPS_W-1:0];
                crsg_pkg::REG_NORMAL_CP: normal_cp_reg <= pwdata[0];
                default:                 normal_cp_reg <= normal_cp_reg;
            endcase
        end
    end

    // Ports 0 and 1 use the first symbol and the third from last; ports 2 and 3 the second.
    always_comb
    begin
        has_rs = 1'b0;
        v_sel  = 3'd0;
        unique case (antenna_port)
            crsg_pkg::PORT_0, crsg_pkg::PORT_1:
            begin
                if (symbol == 3'd0)
                begin
                    has_rs = 1'b1;
                    v_sel  = (antenna_port == crsg_pkg::PORT_0) ? 3'd0 : 3'd3;
                end
                else if (({1'b0, symbol} + 4'd3) == {1'b0, sym_slot_reg})
                begin
                    has_rs = 1'b1;
                    v_sel  = (antenna_port == crsg_pkg::PORT_0) ? 3'd3 : 3'd0;
                end
            end
            crsg_pkg::PORT_2:
            begin
                has_rs = (symbol == 3'd1);
                v_sel  = slot[0] ? 3'd3 : 3'd0;
            end
            default:
            begin
                has_rs = (symbol == 3'd1);
                v_sel  = slot[0] ? 3'd6 : 3'd3;
            end
        endcase
    end

    always_comb
    begin
        rb         = (num_rb_reg > crsg_pkg::RB_W'(crsg_pkg::MAX_RB))
                     ? crsg_pkg::RB_W'(crsg_pkg::MAX_RB) : num_rb_reg;
        skip_len   = crsg_pkg::SKIP_W'(crsg_pkg::GOLD_SKIP)
                     + {3'd0, (crsg_pkg::RB_W'(crsg_pkg::MAX_RB) - rb), 1'b0};
        total      = {rb, 1'b0};
        left_after = left_reg - {4'd0, n_reg};
        is_last    = (left_reg == {4'd0, n_reg});
        emit       = (state_reg == crsg_pkg::ST_GEN) && full_reg
                     && (!out_valid_reg || out_ready);
        in_ready   = (state_reg == crsg_pkg::ST_IDLE);
        in_accept  = in_valid && in_ready;
    end

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        symbol_next    = symbol_reg;
        v_next         = v_reg;
        skip_next      = skip_reg;
        left_next      = left_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        phase_next     = phase_reg;
        full_next      = full_reg;
        re_next        = re_reg;
        im_next        = im_reg;
        loc_next       = loc_reg;
        seed_start     = 1'b0;
        gold_ctrl      = '0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            crsg_pkg::ST_IDLE:
            begin
                if (in_accept && has_rs && (rb != '0))
                begin
                    slot_next   = slot;
                    symbol_next = symbol;
                    v_next      = v_sel;
                    state_next  = crsg_pkg::ST_SEED;
                end
            end
            crsg_pkg::ST_SEED:
            begin
                seed_start = 1'b1;
                state_next = crsg_pkg::ST_LOAD;
            end
            crsg_pkg::ST_LOAD:
            begin
                gold_ctrl.load = 1'b1;
                skip_next      = skip_len;
                left_next      = total;
                loc_next       = {8'd0, freq_shift} + 11'd1;
                state_next     = crsg_pkg::ST_SKIP;
            end
            crsg_pkg::ST_SKIP:
            begin
                gold_ctrl.step = 1'b1;
                skip_next      = skip_reg - 11'd1;
                if (skip_reg == 11'd1)
                begin
                    n_next     = group_size(left_reg);
                    k_next     = '0;
                    phase_next = 1'b0;
                    full_next  = 1'b0;
                    re_next    = '0;
                    im_next    = '0;
                    state_next = crsg_pkg::ST_GEN;
                end
            end
            crsg_pkg::ST_GEN:
            begin
                if (!full_reg)
                begin
                    gold_ctrl.step = 1'b1;
                    if (!phase_reg)
                    begin
                        re_next[k_reg] = gold_bit;
                        phase_next     = 1'b1;
                    end
                    else
                    begin
                        im_next[k_reg] = gold_bit;
                        phase_next     = 1'b0;
                        if ({1'b0, k_reg} == (n_reg - 4'd1))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            k_next = k_reg + 3'd1;
                        end
                    end
                end
                else if (emit)
                begin
                    out_valid_next = 1'b1;
                    left_next      = left_after;
                    loc_next       = loc_reg + crsg_pkg::LOC_W'(crsg_pkg::LOC_STEP);
                    n_next         = group_size(left_after);
                    k_next         = '0;
                    phase_next     = 1'b0;
                    full_next      = 1'b0;
                    re_next        = '0;
                    im_next        = '0;
                    if (is_last)
                    begin
                        state_next = crsg_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = crsg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crsg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            full_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            k_reg         <= '0;
            skip_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            full_reg      <= full_next;
            phase_reg     <= phase_next;
            k_reg         <= k_next;
            skip_reg      <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        symbol_reg <= symbol_next;
        v_reg      <= v_next;
        left_reg   <= left_next;
        n_reg      <= n_next;
        re_reg     <= re_next;
        im_reg     <= im_next;
        loc_reg    <= loc_next;
        if (emit)
        begin
            out_loc_reg  <= loc_reg;
            out_re_reg   <= re_reg;
            out_im_reg   <= im_reg;
            out_cnt_reg  <= n_reg;
            out_last_reg <= is_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign first_location = out_loc_reg;
    assign real_bits      = out_re_reg;
    assign imag_bits      = out_im_reg;
    assign valid_count    = out_cnt_reg;
    assign last_group     = out_last_reg;

endmodule

### hw/rtl/crsg_seed.sv
// Frequency shift and Gold sequence seed for one OFDM symbol, registered on start.
// Depends on crsg_pkg for field widths.
module crsg_seed (
    input  logic                            clk,
    input  logic                            start,
    input  logic [crsg_pkg::SLOT_W-1:0]     slot,
    input  logic [crsg_pkg::SYM_W-1:0]      symbol,
    input  logic [crsg_pkg::CELL_W-1:0]     cell_id,
    input  logic                            normal_cp,
    input  logic [crsg_pkg::SHIFT_W-1:0]    v,
    output logic [crsg_pkg::SEED_W-1:0]     seed,
    output logic [crsg_pkg::SHIFT_W-1:0]    freq_shift
);

    function automatic logic [1:0] mod3_small(input logic [3:0] s);
        logic [1:0] r;
        begin
            unique case (s)
                4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
                4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
                default:                               r = 2'd2;
            endcase
            return r;
        end
    endfunction

    logic [crsg_pkg::SEED_W-1:0]  seed_reg;
    logic [crsg_pkg::SHIFT_W-1:0] shift_reg;
    logic [9:0]                   cell_pad;
    logic [3:0]                   chunk_sum;
    logic [1:0]                   cell_mod3;
    logic [2:0]                   cell_mod6;
    logic [3:0]                   shift_sum;
    logic [5:0]                   slot_inc;
    logic [7:0]                   sym_index;
    logic [9:0]                   cell_odd;
    logic [17:0]                  product;
    logic [crsg_pkg::SEED_W-1:0]  seed_next;
    logic [crsg_pkg::SHIFT_W-1:0] shift_next;

    // Four is one modulo three, so the sum of the base-four digits keeps the residue.
    always_comb
    begin
        cell_pad  = {1'b0, cell_id};
        chunk_sum = 4'd0;
        for (int i = 0; i < 5; i++)
        begin
            chunk_sum = chunk_sum + {2'b00, cell_pad[2*i +: 2]};
        end
        cell_mod3 = mod3_small(chunk_sum);
        cell_mod6 = (cell_mod3[0] == cell_id[0]) ? {1'b0, cell_mod3}
                                                 : ({1'b0, cell_mod3} + 3'd3);
        shift_sum = {1'b0, cell_mod6} + {1'b0, v};
        shift_next = (shift_sum >= 4'd6) ? 3'(shift_sum - 4'd6) : shift_sum[2:0];

        slot_inc  = {1'b0, slot} + 6'd1;
        sym_index = ({2'b00, slot_inc} << 3) - {2'b00, slot_inc}
                    + {5'b00000, symbol} + 8'd1;
        cell_odd  = {cell_id, 1'b1};
        product   = {10'd0, sym_index} * {8'd0, cell_odd};
        seed_next = {3'b000, product, 10'd0}
                    + {21'd0, cell_id, normal_cp};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            seed_reg  <= seed_next;
            shift_reg <= shift_next;
        end
    end

    assign seed       = seed_reg;
    assign freq_shift = shift_reg;

endmodule

### hw/rtl/crsg_gold.sv
// Length-31 Gold sequence generator, one output bit per step.
// Depends on crsg_pkg for the control struct and the seed width.
module crsg_gold (
    input  logic                           clk,
    input  logic                           rst_n,
    input  crsg_pkg::gold_ctrl_t           ctrl,
    input  logic [crsg_pkg::SEED_W-1:0]    seed,
    output logic                           bit_out
);

    logic [crsg_pkg::SEED_W-1:0] lfsr_one_reg;
    logic [crsg_pkg::SEED_W-1:0] lfsr_one_next;
    logic [crsg_pkg::SEED_W-1:0] lfsr_two_reg;
    logic [crsg_pkg::SEED_W-1:0] lfsr_two_next;
    logic                        fb_one;
    logic                        fb_two;

    always_comb
    begin
        fb_one        = lfsr_one_reg[0] ^ lfsr_one_reg[3];
        fb_two        = lfsr_two_reg[0] ^ lfsr_two_reg[1] ^ lfsr_two_reg[2] ^ lfsr_two_reg[3];
        lfsr_one_next = lfsr_one_reg;
        lfsr_two_next = lfsr_two_reg;
        if (ctrl.load)
        begin
            lfsr_one_next = 31'd1;
            lfsr_two_next = seed;
        end
        else if (ctrl.step)
        begin
            lfsr_one_next = {fb_one, lfsr_one_reg[30:1]};
            lfsr_two_next = {fb_two, lfsr_two_reg[30:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_one_reg <= 31'd1;
            lfsr_two_reg <= 31'd0;
        end
        else
        begin
            lfsr_one_reg <= lfsr_one_next;
            lfsr_two_reg <= lfsr_two_next;
        end
    end

    assign bit_out = lfsr_one_reg[0] ^ lfsr_two_reg[0];

endmodule
